/* sv/dq_pkg.sv */
// Shared constants, operation and status codes for the deque ring buffer.
package dq_pkg;

  localparam int unsigned DEPTH_DEF  = 16;
  localparam int unsigned DATA_W_DEF = 32;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_READ       = 3'd4,
    KIND_CLEAR      = 3'd5
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

endpackage

/* sv/dq_if.sv */
// Request and response channel interfaces of the deque ring buffer.
interface dq_in_if;
  import dq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic signed [VALUE_W-1:0] value;
  logic [INDEX_W-1:0]        index;

  modport source (output valid, kind, value, index, input ready);
  modport sink   (input valid, kind, value, index, output ready);
endinterface

interface dq_out_if #(
  parameter int unsigned DEPTH = dq_pkg::DEPTH_DEF
);
  import dq_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] front_value;
  logic signed [VALUE_W-1:0] back_value;
  logic signed [VALUE_W-1:0] read_value;
  logic [CNT_W-1:0]          count;
  logic                      is_empty;
  logic                      is_full;
  logic [STATUS_W-1:0]       status;

  modport source (output valid, front_value, back_value, read_value, count, is_empty,
                  is_full, status, input ready);
  modport sink   (input valid, front_value, back_value, read_value, count, is_empty,
                  is_full, status, output ready);
endinterface

/* sv/dq_mem.sv */
// Entry store: one write port, one read port with registered read data.
module dq_mem #(
  parameter int unsigned DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = dq_pkg::DATA_W_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_WIDTH-1:0]    wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_WIDTH-1:0]    rdata_o
);
  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

/* sv/deque_ring_buffer.sv */
// Top level: double-ended queue over a ring buffer memory.
//
//  channel | dir | interface | payload
//  in_i    | in  | dq_in_if  | kind, value, index
//  out_o   | out | dq_out_if | front/back/read value, count, empty, full, status
//
// Per item: the accept cycle moves the pointers, writes a push and starts the
// one memory read an item may need; the response state then takes the read
// data into the output register, as the single read port's data is registered.
// Reset clears control state, pointers and count; entries are not cleared. A
// result not taken holds the block in its response state, where no new item is taken.
module deque_ring_buffer #(
  parameter int unsigned DEPTH      = dq_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = dq_pkg::DATA_W_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  dq_in_if.sink    in_i,
  dq_out_if.source out_o
);
  import dq_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  localparam logic [PTR_W:0]   DEPTH_SUM = (PTR_W + 1)'(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RESP = 1'b1;

  localparam logic [1:0] SEL_NONE  = 2'd0;
  localparam logic [1:0] SEL_FRONT = 2'd1;
  localparam logic [1:0] SEL_BACK  = 2'd2;
  localparam logic [1:0] SEL_READ  = 2'd3;

  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                               input logic [PTR_W-1:0] off);
    logic [PTR_W:0] sum;
    sum = {1'b0, p} + {1'b0, off};
    if (sum >= DEPTH_SUM) begin
      sum = sum - DEPTH_SUM;
    end
    return sum[PTR_W-1:0];
  endfunction

  logic                state_q, state_d;
  logic [PTR_W-1:0]    head_q, head_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [DATA_WIDTH-1:0] front_q, front_d;
  logic [DATA_WIDTH-1:0] back_q, back_d;
  logic [1:0]          sel_q, sel_d;
  logic [STATUS_W-1:0] status_q, status_d;

  logic                  out_valid_q, out_valid_d;
  logic [VALUE_W-1:0]    out_front_q, out_back_q, out_read_q;
  logic [CNT_W-1:0]      out_count_q;
  logic [STATUS_W-1:0]   out_status_q;

  logic                  accept, resp_load, q_empty, q_full, idx_ok;
  logic [DATA_WIDTH-1:0] wr_data, front_pick, back_pick, mem_rdata;
  logic                  mem_we, mem_re;
  logic [PTR_W-1:0]      mem_waddr, mem_raddr;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign resp_load  = (state_q == ST_RESP) && (!out_valid_q || out_o.ready);

  assign q_empty = (count_q == '0);
  assign q_full  = (count_q == CNT_FULL);
  assign idx_ok  = CMP_W'(in_i.index) < CMP_W'(count_q);
  assign wr_data = DATA_WIDTH'($unsigned(in_i.value));

  // Reads and writes never share a cycle, and a read only ever comes after the
  // previous item's write has been done, so no forwarding is needed.
  always_comb begin
    head_d    = head_q;
    count_d   = count_q;
    front_d   = front_q;
    back_d    = back_q;
    sel_d     = sel_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_waddr = head_q;
    mem_re    = 1'b0;
    mem_raddr = head_q;
    if (accept) begin
      sel_d    = SEL_NONE;
      status_d = STAT_OK;
      unique case (in_i.kind)
        KIND_PUSH_FRONT: begin
          if (q_full) begin
            status_d = STAT_FULL;
          end else begin
            head_d    = (head_q == '0) ? PTR_LAST : head_q - PTR_W'(1);
            mem_we    = 1'b1;
            mem_waddr = head_d;
            count_d   = count_q + CNT_ONE;
            front_d   = wr_data;
            if (q_empty) begin
              back_d = wr_data;
            end
          end
        end
        KIND_PUSH_BACK: begin
          if (q_full) begin
            status_d = STAT_FULL;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = ptr_add(head_q, PTR_W'(count_q));
            count_d   = count_q + CNT_ONE;
            back_d    = wr_data;
            if (q_empty) begin
              front_d = wr_data;
            end
          end
        end
        KIND_POP_FRONT: begin
          if (q_empty) begin
            status_d = STAT_EMPTY;
          end else begin
            head_d  = (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);
            count_d = count_q - CNT_ONE;
            if (count_q >= CNT_TWO) begin
              mem_re    = 1'b1;
              mem_raddr = head_d;
              sel_d     = SEL_FRONT;
            end
          end
        end
        KIND_POP_BACK: begin
          if (q_empty) begin
            status_d = STAT_EMPTY;
          end else begin
            count_d = count_q - CNT_ONE;
            if (count_q >= CNT_TWO) begin
              mem_re    = 1'b1;
              mem_raddr = ptr_add(head_q, PTR_W'(count_q - CNT_TWO));
              sel_d     = SEL_BACK;
            end
          end
        end
        KIND_READ: begin
          if (idx_ok) begin
            mem_re    = 1'b1;
            mem_raddr = ptr_add(head_q, PTR_W'(in_i.index));
            sel_d     = SEL_READ;
          end else begin
            status_d = STAT_RANGE;
          end
        end
        KIND_CLEAR: begin
          head_d  = '0;
          count_d = '0;
        end
        default: begin
        end
      endcase
    end else if (resp_load) begin
      front_d = front_pick;
      back_d  = back_pick;
    end
  end

  assign front_pick = (sel_q == SEL_FRONT) ? mem_rdata : front_q;
  assign back_pick  = (sel_q == SEL_BACK) ? mem_rdata : back_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_RESP;
      ST_RESP: if (resp_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (resp_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      sel_q       <= SEL_NONE;
      status_q    <= STAT_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      sel_q       <= sel_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    back_q  <= back_d;
  end

  always_ff @(posedge clk_i) begin
    if (resp_load) begin
      out_front_q  <= q_empty ? '0 : VALUE_W'(front_pick);
      out_back_q   <= q_empty ? '0 : VALUE_W'(back_pick);
      out_read_q   <= (sel_q == SEL_READ) ? VALUE_W'(mem_rdata) : '0;
      out_count_q  <= count_q;
      out_status_q <= status_q;
    end
  end

  dq_mem #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dq_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (wr_data),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_o.valid       = out_valid_q;
  assign out_o.front_value = out_front_q;
  assign out_o.back_value  = out_back_q;
  assign out_o.read_value  = out_read_q;
  assign out_o.count       = out_count_q;
  assign out_o.is_empty    = (out_count_q == '0);
  assign out_o.is_full     = (out_count_q == CNT_FULL);
  assign out_o.status      = out_status_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("entry count above depth");

  a_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("memory read and write in one cycle");

  a_accept_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_RESP))
    else $error("accepted item did not enter response state");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mem_we) |=> (count_q == $past(count_q) + CNT_ONE))
    else $error("push did not grow the count");
`endif
endmodule

/* dv/tb.sv */
// Testbench for deque_ring_buffer: random and directed deque traffic checked against a predictor.
`timescale 1ns / 100ps

module tb;
  import dq_pkg::*;

  localparam int unsigned DEPTH = DEPTH_DEF;

  // Kinds outside the package enum; the block treats them as no-ops.
  localparam logic [KIND_W-1:0] KIND_RSVD6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RSVD7 = 3'd7;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_e;

  typedef struct {
    logic [VALUE_W-1:0]  front;
    logic [VALUE_W-1:0]  back;
    logic [VALUE_W-1:0]  rd;
    logic [4:0]          cnt;
    logic                empty;
    logic                full;
    logic [STATUS_W-1:0] stat;
  } deque_view_t;

  class deque_scoreboard;
    logic [VALUE_W-1:0] slots [DEPTH];
    logic [3:0]         head;
    logic [4:0]         fill;
    deque_view_t        awaited [$];
    int                 errors;

    function new();
      head   = '0;
      fill   = '0;
      errors = 0;
    endfunction

    // Applies one accepted item to the mirrored deque and queues the result it must give.
    function void note_request(logic [KIND_W-1:0] k, logic [VALUE_W-1:0] v,
                               logic [INDEX_W-1:0] ix);
      deque_view_t exp_r;
      logic [3:0]  slot;
      exp_r.rd   = '0;
      exp_r.stat = STAT_OK;
      case (k)
        KIND_PUSH_FRONT: begin
          if (fill == DEPTH) begin
            exp_r.stat = STAT_FULL;
          end else begin
            head        = head - 1'b1;
            slots[head] = v;
            fill        = fill + 1'b1;
          end
        end
        KIND_PUSH_BACK: begin
          if (fill == DEPTH) begin
            exp_r.stat = STAT_FULL;
          end else begin
            slot        = head + fill[3:0];
            slots[slot] = v;
            fill        = fill + 1'b1;
          end
        end
        KIND_POP_FRONT: begin
          if (fill == 0) begin
            exp_r.stat = STAT_EMPTY;
          end else begin
            head = head + 1'b1;
            fill = fill - 1'b1;
          end
        end
        KIND_POP_BACK: begin
          if (fill == 0) exp_r.stat = STAT_EMPTY;
          else fill = fill - 1'b1;
        end
        KIND_READ: begin
          if (ix < fill) begin
            slot     = head + ix;
            exp_r.rd = slots[slot];
          end else begin
            exp_r.stat = STAT_RANGE;
          end
        end
        KIND_CLEAR: begin
          head = '0;
          fill = '0;
        end
        default: ;
      endcase
      slot        = head + fill[3:0] - 1'b1;  // wraps to the last slot when full
      exp_r.front = (fill != 0) ? slots[head] : '0;
      exp_r.back  = (fill != 0) ? slots[slot] : '0;
      exp_r.cnt   = fill;
      exp_r.empty = (fill == 0);
      exp_r.full  = (fill == DEPTH);
      awaited     = {awaited, exp_r};
    endfunction

    function void compare_field(string name, logic [VALUE_W-1:0] exp_v,
                                logic [VALUE_W-1:0] got_v);
      if (got_v !== exp_v) begin
        errors++;
        if (errors <= 10) $display("mismatch on %s: expected %h, got %h", name, exp_v, got_v);
      end
    endfunction

    function void check_response(deque_view_t got);
      deque_view_t exp_r;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result with nothing awaited: front %h back %h count %0d status %0d",
                   got.front, got.back, got.cnt, got.stat);
        return;
      end
      exp_r = awaited[0];
      awaited.delete(0);
      compare_field("front_value", exp_r.front, got.front);
      compare_field("back_value", exp_r.back, got.back);
      compare_field("read_value", exp_r.rd, got.rd);
      compare_field("count", VALUE_W'(exp_r.cnt), VALUE_W'(got.cnt));
      compare_field("is_empty", VALUE_W'(exp_r.empty), VALUE_W'(got.empty));
      compare_field("is_full", VALUE_W'(exp_r.full), VALUE_W'(got.full));
      compare_field("status", VALUE_W'(exp_r.stat), VALUE_W'(got.stat));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  always #4 clk_i = ~clk_i;

  dq_in_if                   in_ch ();
  dq_out_if #(.DEPTH(DEPTH)) out_ch ();

  deque_ring_buffer #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_W_DEF)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  deque_scoreboard sb;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;

  // Sink side: random stalls, plus a long hold-off on request.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    deque_view_t got;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) sb.note_request(in_ch.kind, in_ch.value, in_ch.index);
      if (out_ch.valid && out_ch.ready) begin
        got.front = out_ch.front_value;
        got.back  = out_ch.back_value;
        got.rd    = out_ch.read_value;
        got.cnt   = out_ch.count;
        got.empty = out_ch.is_empty;
        got.full  = out_ch.is_full;
        got.stat  = out_ch.status;
        sb.check_response(got);
      end
    end
  end

  // Returns at the edge on which the item is taken; valid stays high for a following item.
  task automatic send_item(input logic [KIND_W-1:0] k, input logic [VALUE_W-1:0] v,
                           input logic [INDEX_W-1:0] ix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= k;
    in_ch.value <= v;
    in_ch.index <= ix;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (sb.awaited.size() != 0);
  endtask

  task automatic send_random(traffic_mode_e mode);
    int                 r;
    int                 push_pct;
    logic [KIND_W-1:0]  k;
    logic [VALUE_W-1:0] v;
    logic [INDEX_W-1:0] ix;
    push_pct = (mode == MODE_FILL) ? 75 : (mode == MODE_DRAIN) ? 25 : 50;
    r = $urandom_range(99);
    if (r < 2) k = KIND_CLEAR;
    else if (r < 4) k = (r == 3) ? KIND_RSVD7 : KIND_RSVD6;
    else if (r < 20) k = KIND_READ;
    else if ($urandom_range(99) < push_pct) k = $urandom_range(1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
    else k = $urandom_range(1) ? KIND_POP_BACK : KIND_POP_FRONT;
    case ($urandom_range(15))
      0:       v = 32'h8000_0000;
      1:       v = 32'h7fff_ffff;
      2:       v = '1;
      3:       v = '0;
      default: v = $urandom();
    endcase
    // mostly in-range reads, some beyond the count
    if (sb.fill != 0 && $urandom_range(3) != 0) ix = INDEX_W'($urandom_range(sb.fill - 1));
    else ix = INDEX_W'($urandom_range(15));
    send_item(k, v, ix);
  endtask

  initial begin : main
    logic [VALUE_W-1:0] corner_vals [4];
    traffic_mode_e      mode;
    corner_vals = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff};
    mode        = MODE_MIXED;
    sb          = new();
    rst_ni      = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.kind  <= KIND_CLEAR;
    in_ch.value <= '0;
    in_ch.index <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty pops and read, fill to full, rejected pushes, reads at index 15, no-op kinds, pops, clear
    send_item(KIND_POP_FRONT, '0, '0);
    send_item(KIND_POP_BACK, '0, '0);
    send_item(KIND_READ, '0, '0);
    for (int i = 0; i < DEPTH; i++) begin
      send_item((i % 2 == 0) ? KIND_PUSH_FRONT : KIND_PUSH_BACK,
                (i < 4) ? corner_vals[i] : $urandom(), INDEX_W'($urandom_range(15)));
    end
    send_item(KIND_PUSH_FRONT, 32'h1234_5678, '0);
    send_item(KIND_PUSH_BACK, 32'h8765_4321, '0);
    send_item(KIND_READ, '0, 4'd15);
    send_item(KIND_RSVD6, '1, '1);
    send_item(KIND_POP_FRONT, '0, '0);
    send_item(KIND_POP_BACK, '0, '0);
    send_item(KIND_READ, '0, 4'd15);
    send_item(KIND_RSVD7, '0, '0);
    send_item(KIND_CLEAR, '0, '0);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_req       = 90;  // sink blocked while items keep coming
        end
        1: begin
          send_idle_pct  = 84;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 84;
        end
        default: begin
          send_idle_pct  = 34;
          recv_stall_pct = 34;
        end
      endcase
      for (int i = 0; i < 230; i++) begin
        if (i % 40 == 0) mode = traffic_mode_e'($urandom_range(2));
        send_random(mode);
      end
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("[deque_ring_buffer] OK");
    end else begin
      $display("[deque_ring_buffer] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("[deque_ring_buffer] ERROR");
    $finish;
  end

endmodule
